>>> design/b64_pkg.sv
`default_nettype none
package b64_pkg;

  localparam int unsigned GroupW = 24;
  localparam logic [7:0] PadChar = 8'h3D;

  typedef enum logic [0:0] {
    REG_URL_ALPHABET = 1'b0,
    REG_PAD_ENABLE   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [GroupW-1:0] group;
    logic [1:0]        data_last;
    logic [1:0]        char_last;
    logic              eom;
  } b64_entry_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx, input logic url);
    logic [7:0] code;
    begin
      code = {2'b00, idx};
      if (idx < 6'd26) begin
        b64_char = 8'h41 + code;
      end else if (idx < 6'd52) begin
        b64_char = 8'h61 + code - 8'd26;
      end else if (idx < 6'd62) begin
        b64_char = 8'h30 + code - 8'd52;
      end else if (idx == 6'd62) begin
        b64_char = url ? 8'h2D : 8'h2B;
      end else begin
        b64_char = url ? 8'h5F : 8'h2F;
      end
    end
  endfunction

endpackage
`default_nettype wire

>>> design/base64_encoder.sv
`default_nettype none
// a group-completing byte is written into the group queue, then its first character into the output register
// output: one character per cycle while a group is queued and m_tready is high, four characters per full group
// the output character register sets the rate; a 2-entry group queue decouples input
// reset: synchronous active high rst clears pending bytes, queue and output valid
// after reset url_alphabet is 0 and pad_enable is 1
module base64_encoder
  import b64_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // data_byte
  input  wire logic       s_tlast,   // end_of_message
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_char
  output logic            m_tlast,   // last_char
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [0:0] cfg_data
);

  logic       url_alphabet;
  logic       pad_enable;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       head_valid;
  b64_entry_t push_entry;
  b64_entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet <= 1'b0;
      pad_enable   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_URL_ALPHABET: url_alphabet <= cfg_data[0];
        REG_PAD_ENABLE:   pad_enable   <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  b64_front u_front (
    .clk            (clk),
    .rst            (rst),
    .pad_enable     (pad_enable),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .data_byte      (s_tdata),
    .end_of_message (s_tlast),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  b64_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64_back u_back (
    .clk          (clk),
    .rst          (rst),
    .url_alphabet (url_alphabet),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_char     (m_tdata),
    .last_char    (m_tlast)
  );

endmodule
`default_nettype wire

>>> design/b64_front.sv
`default_nettype none
module b64_front
  import b64_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pad_enable,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  input  wire logic       q_full,
  output logic            push,
  output b64_entry_t      push_entry
);

  logic [15:0] pending_bytes;
  logic [15:0] pending_bytes_next;
  logic [1:0]  pending_count;
  logic [1:0]  pending_count_next;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pending_bytes_next   = pending_bytes;
    pending_count_next   = pending_count;
    push                 = 1'b0;
    push_entry.group     = '0;
    push_entry.data_last = 2'd3;
    push_entry.char_last = 2'd3;
    push_entry.eom       = end_of_message;
    case (pending_count)
      2'd2: begin
        push_entry.group = {pending_bytes, data_byte};
        if (accept) begin
          push               = 1'b1;
          pending_bytes_next = '0;
          pending_count_next = 2'd0;
        end
      end
      2'd1: begin
        push_entry.group     = {pending_bytes[15:8], data_byte, 8'h00};
        push_entry.data_last = 2'd2;
        push_entry.char_last = pad_enable ? 2'd3 : 2'd2;
        if (accept) begin
          if (end_of_message) begin
            push               = 1'b1;
            pending_bytes_next = '0;
            pending_count_next = 2'd0;
          end else begin
            pending_bytes_next = {pending_bytes[15:8], data_byte};
            pending_count_next = 2'd2;
          end
        end
      end
      default: begin
        push_entry.group     = {data_byte, 16'h0000};
        push_entry.data_last = 2'd1;
        push_entry.char_last = pad_enable ? 2'd3 : 2'd1;
        if (accept) begin
          if (end_of_message) begin
            push               = 1'b1;
            pending_bytes_next = '0;
            pending_count_next = 2'd0;
          end else begin
            pending_bytes_next = {data_byte, 8'h00};
            pending_count_next = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= '0;
      pending_count <= 2'd0;
    end else begin
      pending_bytes <= pending_bytes_next;
      pending_count <= pending_count_next;
    end
  end

  property p_count_range;
    @(posedge clk) disable iff (rst) pending_count != 2'd3;
  endproperty
  assert property (p_count_range) else $error("pending count out of range");

  property p_push_needs_accept;
    @(posedge clk) disable iff (rst) push |-> accept;
  endproperty
  assert property (p_push_needs_accept) else $error("push without transaction");

  property p_full_group_clears;
    @(posedge clk) disable iff (rst) (accept && pending_count == 2'd2) |=> pending_count == 2'd0;
  endproperty
  assert property (p_full_group_clears) else $error("group not cleared");

endmodule
`default_nettype wire

>>> design/b64_fifo.sv
`default_nettype none
module b64_fifo
  import b64_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire b64_entry_t push_entry,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output b64_entry_t      head
);

  b64_entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) !(push && full);
  endproperty
  assert property (p_no_overflow) else $error("queue overflow");

  property p_no_underflow;
    @(posedge clk) disable iff (rst) !(pop && !head_valid);
  endproperty
  assert property (p_no_underflow) else $error("queue underflow");

  property p_count_ptrs;
    @(posedge clk) disable iff (rst) (count == 2'd1) |-> (wr_ptr != rd_ptr);
  endproperty
  assert property (p_count_ptrs) else $error("pointer mismatch");

endmodule
`default_nettype wire

>>> design/b64_back.sv
`default_nettype none
module b64_back
  import b64_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       url_alphabet,
  input  wire logic       head_valid,
  input  wire b64_entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            last_char
);

  logic [1:0] char_idx;
  logic [1:0] char_idx_next;
  logic       load;
  logic [5:0] sextet;
  logic [7:0] char_next;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && (char_idx == head.char_last);

  always_comb begin
    case (char_idx)
      2'd0:    sextet = head.group[23:18];
      2'd1:    sextet = head.group[17:12];
      2'd2:    sextet = head.group[11:6];
      default: sextet = head.group[5:0];
    endcase
    char_next = (char_idx <= head.data_last) ? b64_char(sextet, url_alphabet) : PadChar;
    if (pop) begin
      char_idx_next = 2'd0;
    end else if (load) begin
      char_idx_next = char_idx + 2'd1;
    end else begin
      char_idx_next = char_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_idx  <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      char_idx <= char_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= char_next;
      last_char <= pop && head.eom;
    end
  end

  property p_idx_in_range;
    @(posedge clk) disable iff (rst) head_valid |-> (char_idx <= head.char_last);
  endproperty
  assert property (p_idx_in_range) else $error("character index past group end");

  property p_idle_idx_zero;
    @(posedge clk) disable iff (rst) !head_valid |-> (char_idx == 2'd0);
  endproperty
  assert property (p_idle_idx_zero) else $error("index not reset between groups");

  property p_last_only_on_pop;
    @(posedge clk) disable iff (rst) (load && !pop) |=> !last_char;
  endproperty
  assert property (p_last_only_on_pop) else $error("last flag inside group");

endmodule
`default_nettype wire

>>> bench/base64_encoder_tb.sv
module base64_encoder_tb;
  import b64_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  localparam int HoldCycles = 300;
  localparam int BytesPerPhase = 72;

  // running base64 encoder state plus the characters still owed by the block
  class encoded_stream;
    string std_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string url_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    logic        url_sel = 1'b0;
    logic        pad_on = 1'b1;
    logic [15:0] held = '0;
    logic [1:0]  held_cnt = '0;
    enc_char_t   chars_due[$];
    int errors = 0;
    int bytes_in = 0;
    int chars_seen = 0;
    int messages = 0;

    function void set_reg(cfg_reg_t idx, logic val);
      if (idx == REG_URL_ALPHABET) begin
        url_sel = val;
      end else begin
        pad_on = val;
      end
    endfunction

    function logic [7:0] sextet_char(logic [5:0] idx);
      return url_sel ? url_set[idx] : std_set[idx];
    endfunction

    function void owe(logic [7:0] ch, logic last);
      enc_char_t c;
      c.ch = ch;
      c.last = last;
      chars_due = {chars_due, c};
    endfunction

    function void note_byte(logic [7:0] b, logic eom);
      logic [23:0] grp;
      bytes_in++;
      if (eom) begin
        messages++;
      end
      if (held_cnt == 2'd3) begin
        held_cnt = 2'd0;
      end
      if (held_cnt == 2'd2) begin
        grp = {held, b};
        owe(sextet_char(grp[23:18]), 1'b0);
        owe(sextet_char(grp[17:12]), 1'b0);
        owe(sextet_char(grp[11:6]), 1'b0);
        owe(sextet_char(grp[5:0]), eom);
        held = '0;
        held_cnt = 2'd0;
        return;
      end
      if (!eom) begin
        if (held_cnt == 2'd0) begin
          held = {b, 8'h00};
        end else begin
          held[7:0] = b;
        end
        held_cnt++;
        return;
      end
      if (held_cnt == 2'd0) begin
        grp = {b, 16'h0000};
        owe(sextet_char(grp[23:18]), 1'b0);
        owe(sextet_char(grp[17:12]), !pad_on);
        if (pad_on) begin
          owe(PadChar, 1'b0);
          owe(PadChar, 1'b1);
        end
      end else begin
        grp = {held[15:8], b, 8'h00};
        owe(sextet_char(grp[23:18]), 1'b0);
        owe(sextet_char(grp[17:12]), 1'b0);
        owe(sextet_char(grp[11:6]), !pad_on);
        if (pad_on) begin
          owe(PadChar, 1'b1);
        end
      end
      held = '0;
      held_cnt = 2'd0;
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      enc_char_t want;
      chars_seen++;
      if (chars_due.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, ch, last);
        errors++;
        return;
      end
      want = chars_due.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: out_char mismatch expected %h got %h", $time, want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_char mismatch expected %b got %b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return chars_due.size();
    endfunction

    function void flush_check();
      while (chars_due.size() != 0) begin
        $display("%0t: missing character expected %h last %b", $time,
                 chars_due[0].ch, chars_due[0].last);
        void'(chars_due.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [0:0] cfg_data;

  encoded_stream sb;
  int       burst_left = 0;
  bit       hold_req = 1'b0;
  int       hold_left = 0;
  int       mode_left = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  base64_encoder dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_char(m_tdata, m_tlast);
    end
  end

  // receiver stall patterns, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_left == 0 && hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 60);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN: m_tready <= 1'b1;
          RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_tick % 4 != 3);
        endcase
      end
    end
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom_range(8'hF8, 8'hFF));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b, eom);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_random_message();
    int len;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(10, 40);
    end else begin
      len = $urandom_range(1, 9);
    end
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1);
    end
  endtask

  task automatic drain(input int settle);
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  initial begin
    int target;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_URL_ALPHABET;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: standard alphabet with padding
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hBF, 1'b1);
    send_byte(8'h4D, 1'b0); send_byte(8'h61, 1'b0); send_byte(8'h6E, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0); send_byte(8'h55, 1'b0); send_byte(8'hAA, 1'b1);
    drain(8);
    write_reg(REG_PAD_ENABLE, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b1);
    drain(8);
    write_reg(REG_URL_ALPHABET, 1'b1);
    send_byte(8'hFB, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hBF, 1'b1);
    send_byte(8'hFE, 1'b0); send_byte(8'hFF, 1'b1);

    target = sb.bytes_in;
    for (int p = 0; p < 4; p++) begin
      drain(8);
      write_reg(REG_URL_ALPHABET, p[0]);
      write_reg(REG_PAD_ENABLE, p[1]);
      if (p == 1) begin
        hold_req = 1'b1;
      end
      target += BytesPerPhase;
      while (sb.bytes_in < target) begin
        send_random_message();
      end
    end

    drain(10);
    sb.flush_check();
    $display("covered %0d messages, %0d bytes, %0d characters checked", sb.messages,
             sb.bytes_in, sb.chars_seen);
    $display("all alphabet and padding settings, random stalls and one long output hold-off");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
